### src/ircansi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ircansi_pkg
// Shared types, byte codes and the colour escape table of the IRC to ANSI
// translator.
// ----------------------------------------------------------------------------
package ircansi_pkg;

  localparam int RUN_MAX = 12;

  localparam logic [7:0] CH_CTRL_B = 8'h02;
  localparam logic [7:0] CH_CTRL_C = 8'h03;
  localparam logic [7:0] CH_BEL    = 8'h07;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_CTRL_O = 8'h0F;
  localparam logic [7:0] CH_CTRL_V = 8'h16;
  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_CTRL_US = 8'h1F;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_1      = 8'h31;
  localparam logic [7:0] CH_2      = 8'h32;
  localparam logic [7:0] CH_3      = 8'h33;
  localparam logic [7:0] CH_4      = 8'h34;
  localparam logic [7:0] CH_7      = 8'h37;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_M      = 8'h6D;

  localparam logic [4:0] COLOUR_MAP [16] = '{
    5'd0, 5'd7, 5'd4, 5'd2, 5'd1, 5'd3, 5'd5, 5'd11,
    5'd13, 5'd12, 5'd6, 5'd16, 5'd14, 5'd15, 5'd10, 5'd7
  };

  typedef enum logic [1:0] {
    MODE_TEXT,
    MODE_AFTER_CC,
    MODE_DIGITS,
    MODE_SPARE
  } mode_t;

  typedef struct packed {
    mode_t      mode;
    logic [1:0] digit_count;
    logic [6:0] colour_number;
    logic       background;
    logic       reverse_on;
    logic       underline_on;
    logic       bold_on;
  } state_t;

  typedef logic [RUN_MAX-1:0][7:0] run_t;

  typedef struct packed {
    run_t       bytes;
    logic [3:0] count;
    state_t     next;
  } step_t;

  typedef struct packed {
    logic [5:0][7:0] bytes;
    logic [2:0]      len;
  } colour_seq_t;

  typedef struct packed {
    logic [4:0][7:0] bytes;
    logic [2:0]      len;
  } sgr_seq_t;

  // ESC [ <code> m for one colour table entry, first byte in element 0
  function automatic colour_seq_t colour_seq(logic [3:0] idx, logic bg);
    colour_seq_t s;
    logic [4:0]  m;
    logic [4:0]  r;
    s = '0;
    m = COLOUR_MAP[idx];
    r = m - 5'd10;
    s.bytes[0] = CH_ESC;
    s.bytes[1] = CH_LBRACK;
    if (m < 5'd10) begin
      s.bytes[2] = bg ? CH_4 : CH_3;
      s.bytes[3] = CH_0 + {3'b000, m};
      s.bytes[4] = CH_M;
      s.len      = 3'd5;
    end else if (bg) begin
      s.bytes[2] = CH_1;
      s.bytes[3] = CH_0;
      s.bytes[4] = CH_0 + {3'b000, r};
      s.bytes[5] = CH_M;
      s.len      = 3'd6;
    end else begin
      s.bytes[2] = CH_9;
      s.bytes[3] = CH_0 + {3'b000, r};
      s.bytes[4] = CH_M;
      s.len      = 3'd5;
    end
    return s;
  endfunction

  // ESC [ [d1] d0 m
  function automatic sgr_seq_t sgr_seq(logic two, logic [7:0] d1, logic [7:0] d0);
    sgr_seq_t s;
    s = '0;
    s.bytes[0] = CH_ESC;
    s.bytes[1] = CH_LBRACK;
    if (two) begin
      s.bytes[2] = d1;
      s.bytes[3] = d0;
      s.bytes[4] = CH_M;
      s.len      = 3'd5;
    end else begin
      s.bytes[2] = d0;
      s.bytes[3] = CH_M;
      s.len      = 3'd4;
    end
    return s;
  endfunction

endpackage
`default_nettype wire

### src/ircansi_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ircansi channel interfaces
// Valid/ready channels for message bytes in and terminal bytes out.
// ----------------------------------------------------------------------------
interface ircansi_msg_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_message;

  modport source (output valid, output in_byte, output end_of_message, input ready);
  modport sink (input valid, input in_byte, input end_of_message, output ready);
endinterface

interface ircansi_ansi_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       message_done;

  modport source (output valid, output out_byte, output last_of_run,
                  output message_done, input ready);
  modport sink (input valid, input out_byte, input last_of_run,
                input message_done, output ready);
endinterface
`default_nettype wire

### src/ircansi_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ircansi_decode
// Translates one message byte against the parser state into a run of up to
// twelve terminal bytes and the parser state that follows.
// ----------------------------------------------------------------------------
module ircansi_decode (
  input  wire logic [7:0]          in_byte,
  input  wire logic                end_of_message,
  input  wire logic                drop_beep,
  input  wire ircansi_pkg::state_t state,
  output ircansi_pkg::step_t       step
);

  ircansi_pkg::state_t      nxt;
  ircansi_pkg::colour_seq_t pre;
  ircansi_pkg::colour_seq_t col;
  ircansi_pkg::sgr_seq_t    txt;
  logic [3:0][7:0]          suf;
  logic [2:0]               ls;
  logic                     do_text;
  logic                     is_digit;
  logic [10:0]              acc;
  logic [5:0]               pre_sh;
  logic [5:0]               suf_sh;
  logic [95:0]              packed_run;

  assign is_digit = (in_byte inside {[ircansi_pkg::CH_0:ircansi_pkg::CH_9]});
  assign acc      = 11'(state.colour_number * 4'd10) + {7'b0, in_byte[3:0]};
  assign col      = ircansi_pkg::colour_seq(state.colour_number[3:0], state.background);

  always_comb begin
    nxt     = state;
    pre     = '0;
    txt     = '0;
    suf     = '0;
    ls      = 3'd0;
    do_text = 1'b0;

    case (state.mode)
      ircansi_pkg::MODE_AFTER_CC: begin
        if (is_digit) begin
          nxt.mode          = ircansi_pkg::MODE_DIGITS;
          nxt.digit_count   = 2'd1;
          nxt.colour_number = {3'b000, in_byte[3:0]};
          nxt.background    = 1'b0;
        end else begin
          pre.bytes[0] = ircansi_pkg::CH_ESC;
          pre.bytes[1] = ircansi_pkg::CH_LBRACK;
          pre.bytes[2] = ircansi_pkg::CH_M;
          pre.len      = 3'd3;
          nxt.mode     = ircansi_pkg::MODE_TEXT;
          do_text      = 1'b1;
        end
      end
      ircansi_pkg::MODE_DIGITS: begin
        if (is_digit && state.digit_count < 2'd2) begin
          nxt.colour_number = acc[6:0];
          nxt.digit_count   = state.digit_count + 2'd1;
        end else begin
          if (state.digit_count != 2'd0) begin
            pre = col;
          end else begin
            pre.bytes[0] = ircansi_pkg::CH_ESC;
            pre.bytes[1] = ircansi_pkg::CH_LBRACK;
            pre.bytes[2] = ircansi_pkg::CH_M;
            pre.len      = 3'd3;
          end
          nxt.digit_count   = 2'd0;
          nxt.colour_number = 7'd0;
          if (in_byte == ircansi_pkg::CH_COMMA) begin
            nxt.background = 1'b1;
          end else begin
            nxt.mode = ircansi_pkg::MODE_TEXT;
            do_text  = 1'b1;
          end
        end
      end
      default: begin
        nxt.mode = ircansi_pkg::MODE_TEXT;
        do_text  = 1'b1;
      end
    endcase

    if (do_text) begin
      case (in_byte)
        ircansi_pkg::CH_CTRL_C: begin
          nxt.mode = ircansi_pkg::MODE_AFTER_CC;
        end
        ircansi_pkg::CH_BS: begin
        end
        ircansi_pkg::CH_CTRL_V: begin
          txt = ircansi_pkg::sgr_seq(state.reverse_on, ircansi_pkg::CH_2,
                                     state.reverse_on ? ircansi_pkg::CH_7 : ircansi_pkg::CH_7);
          nxt.reverse_on = ~state.reverse_on;
        end
        ircansi_pkg::CH_CTRL_US: begin
          txt = ircansi_pkg::sgr_seq(state.underline_on, ircansi_pkg::CH_2,
                                     ircansi_pkg::CH_4);
          nxt.underline_on = ~state.underline_on;
        end
        ircansi_pkg::CH_CTRL_B: begin
          txt = ircansi_pkg::sgr_seq(state.bold_on, ircansi_pkg::CH_2,
                                     state.bold_on ? ircansi_pkg::CH_2 : ircansi_pkg::CH_1);
          nxt.bold_on = ~state.bold_on;
        end
        ircansi_pkg::CH_BEL: begin
          if (!drop_beep) begin
            txt.bytes[0] = in_byte;
            txt.len      = 3'd1;
          end
        end
        ircansi_pkg::CH_CTRL_O: begin
          txt.bytes[0]     = ircansi_pkg::CH_ESC;
          txt.bytes[1]     = ircansi_pkg::CH_LBRACK;
          txt.bytes[2]     = ircansi_pkg::CH_M;
          txt.len          = 3'd3;
          nxt.reverse_on   = 1'b0;
          nxt.underline_on = 1'b0;
          nxt.bold_on      = 1'b0;
        end
        ircansi_pkg::CH_TAB: begin
          txt.bytes[0] = ircansi_pkg::CH_SPACE;
          txt.len      = 3'd1;
        end
        ircansi_pkg::CH_LF: begin
          txt.bytes[0] = ircansi_pkg::CH_CR;
          txt.bytes[1] = ircansi_pkg::CH_LF;
          txt.len      = 3'd2;
        end
        default: begin
          txt.bytes[0] = in_byte;
          txt.len      = 3'd1;
        end
      endcase
    end

    // message end: close a bare ctrl-c, add a newline, back to reset state
    if (end_of_message) begin
      if (nxt.mode == ircansi_pkg::MODE_AFTER_CC) begin
        suf[0] = ircansi_pkg::CH_ESC;
        suf[1] = ircansi_pkg::CH_LBRACK;
        suf[2] = ircansi_pkg::CH_M;
        ls     = 3'd3;
      end
      if (in_byte != ircansi_pkg::CH_LF) begin
        suf[ls[1:0]] = ircansi_pkg::CH_LF;
        ls           = ls + 3'd1;
      end
      nxt = '0;
    end
  end

  assign pre_sh = {3'b000, pre.len};
  assign suf_sh = {3'b000, pre.len} + {3'b000, txt.len};

  assign packed_run = {48'b0, pre.bytes}
                    | ({56'b0, txt.bytes} << {pre_sh, 3'b000})
                    | ({64'b0, suf} << {suf_sh, 3'b000});

  assign step.bytes = packed_run;
  assign step.count = {1'b0, pre.len} + {1'b0, txt.len} + {1'b0, ls};
  assign step.next  = nxt;

endmodule
`default_nettype wire

### src/irc_format_to_ansi_translator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// irc_format_to_ansi_translator
// Turns IRC formatted message text into a terminal byte stream with ANSI
// colour and attribute escapes.
// ----------------------------------------------------------------------------
// msg carries one message byte per item, end_of_message on the last byte.
// ansi carries one terminal byte per item; last_of_run marks the final byte
// caused by one message byte, message_done the final byte of the message.
// cfg_we/cfg_wdata write drop_beep, which removes BEL bytes when set.
// A message byte is held in an input register, translated combinationally
// into a run of 0 to 12 bytes and loaded into a run shift register that
// drives ansi. Throughput: one ansi byte per cycle while ansi.ready is high.
// A message byte is taken every cycle as long as each yields at most one
// byte and ansi.ready is high; a longer run holds the next one until the
// run's last byte is taken. Bytes that yield nothing pass through without
// waiting for the run register.
// Reset clears the parser state, the attribute flags, drop_beep and both
// registers. When the receiver stalls, the run holds; the input register still
// takes message bytes until one yields a run, and then msg.ready drops.
// ----------------------------------------------------------------------------
module irc_format_to_ansi_translator (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic         cfg_wdata,
  ircansi_msg_if.sink       msg,
  ircansi_ansi_if.source    ansi
);

  logic                drop_beep;
  ircansi_pkg::state_t state;
  logic                hold_valid;
  logic [7:0]          hold_byte;
  logic                hold_eom;
  ircansi_pkg::run_t   run_bytes;
  logic [3:0]          run_count;
  logic                run_eom;
  ircansi_pkg::step_t  step;
  logic                pop;
  logic                run_free;
  logic                consume;

  ircansi_decode u_decode (
    .in_byte        (hold_byte),
    .end_of_message (hold_eom),
    .drop_beep      (drop_beep),
    .state          (state),
    .step           (step)
  );

  assign pop      = ansi.valid && ansi.ready;
  assign run_free = (run_count == 4'd0) || (pop && run_count == 4'd1);
  assign consume  = hold_valid && ((step.count == 4'd0) || run_free);

  assign msg.ready = !hold_valid || consume;

  assign ansi.valid        = (run_count != 4'd0);
  assign ansi.out_byte     = run_bytes[0];
  assign ansi.last_of_run  = (run_count == 4'd1);
  assign ansi.message_done = run_eom && (run_count == 4'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      drop_beep <= 1'b0;
    end else if (cfg_we) begin
      drop_beep <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (msg.valid && msg.ready) begin
      hold_valid <= 1'b1;
    end else if (consume) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (msg.valid && msg.ready) begin
      hold_byte <= msg.in_byte;
      hold_eom  <= msg.end_of_message;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (consume) begin
      state <= step.next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_count <= 4'd0;
    end else if (consume && step.count != 4'd0) begin
      run_count <= step.count;
    end else if (pop) begin
      run_count <= run_count - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && step.count != 4'd0) begin
      run_bytes <= step.bytes;
      run_eom   <= hold_eom;
    end else if (pop) begin
      run_bytes <= {8'h00, run_bytes[ircansi_pkg::RUN_MAX-1:1]};
    end
  end

endmodule
`default_nettype wire

### tb/irc_format_to_ansi_translator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irc_format_to_ansi_translator_tb
// Feeds IRC formatted messages into the translator one byte per item and
// compares every terminal byte against a local translation of the stream.
// A typed table of directed bytes comes first, then random messages built
// from text, colour codes and control bytes, with drop_beep toggled between
// phases and random gaps on both channels.
// ----------------------------------------------------------------------------
module irc_format_to_ansi_translator_tb;

  localparam int SETTLE = 4;
  localparam int PHASE_ITEMS = 100;
  localparam logic [7:0] CH_NUL = 8'h00;

  typedef struct {
    logic [7:0] data;
    logic       eom;
    bit         typed;
    string      want;
  } dir_row_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       done;
  } ansi_byte_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we;
  logic cfg_wdata;

  ircansi_msg_if  msg ();
  ircansi_ansi_if ansi ();

  irc_format_to_ansi_translator dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .msg       (msg),
    .ansi      (ansi)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // translator state as seen from outside
  ircansi_pkg::mode_t pmode;
  logic [1:0] ndig;
  logic [6:0] cnum;
  logic       bgf;
  logic       rev_on;
  logic       ul_on;
  logic       bold_on;
  logic       drop_beep;

  logic [7:0] term_run[$];
  ansi_byte_t ansi_due[$];
  logic [7:0] msg_text[$];
  dir_row_t   dir_rows[$];
  int         mismatch_count = 0;
  int         items_sent = 0;
  bit         tx_calm = 1'b0;
  bit         rx_calm = 1'b0;

  task automatic flag_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic void clear_parse();
    pmode   = ircansi_pkg::MODE_TEXT;
    ndig    = 2'd0;
    cnum    = 7'd0;
    bgf     = 1'b0;
    rev_on  = 1'b0;
    ul_on   = 1'b0;
    bold_on = 1'b0;
  endfunction

  function automatic void emit(input logic [7:0] b);
    if (term_run.size() < ircansi_pkg::RUN_MAX) term_run.push_back(b);
  endfunction

  function automatic void emit_esc(input string code);
    emit(ircansi_pkg::CH_ESC);
    emit(ircansi_pkg::CH_LBRACK);
    for (int i = 0; i < code.len(); i++) emit(code[i]);
    emit(ircansi_pkg::CH_M);
  endfunction

  function automatic void emit_colour();
    int v;
    emit(ircansi_pkg::CH_ESC);
    emit(ircansi_pkg::CH_LBRACK);
    if (ndig != 2'd0) begin
      v = ircansi_pkg::COLOUR_MAP[cnum[3:0]];
      if (v > 9) v += 50;
      v += bgf ? 40 : 30;
      if (v >= 100) begin
        emit(ircansi_pkg::CH_1);
        v -= 100;
      end
      emit(8'(ircansi_pkg::CH_0 + v / 10));
      emit(8'(ircansi_pkg::CH_0 + v % 10));
    end
    emit(ircansi_pkg::CH_M);
  endfunction

  function automatic void plain_byte(input logic [7:0] b);
    case (b)
      ircansi_pkg::CH_CTRL_C: pmode = ircansi_pkg::MODE_AFTER_CC;
      ircansi_pkg::CH_BS: ;
      ircansi_pkg::CH_CTRL_V: begin
        if (rev_on) emit_esc("27");
        else emit_esc("7");
        rev_on = !rev_on;
      end
      ircansi_pkg::CH_CTRL_US: begin
        if (ul_on) emit_esc("24");
        else emit_esc("4");
        ul_on = !ul_on;
      end
      ircansi_pkg::CH_CTRL_B: begin
        if (bold_on) emit_esc("22");
        else emit_esc("1");
        bold_on = !bold_on;
      end
      ircansi_pkg::CH_BEL: begin
        if (!drop_beep) emit(b);
      end
      ircansi_pkg::CH_CTRL_O: begin
        emit_esc("");
        rev_on  = 1'b0;
        ul_on   = 1'b0;
        bold_on = 1'b0;
      end
      ircansi_pkg::CH_TAB: emit(ircansi_pkg::CH_SPACE);
      ircansi_pkg::CH_LF: begin
        emit(ircansi_pkg::CH_CR);
        emit(ircansi_pkg::CH_LF);
      end
      default: emit(b);
    endcase
  endfunction

  // terminal bytes caused by one message byte, left in term_run
  function automatic void translate_byte(input logic [7:0] b, input logic eom);
    logic is_dig;
    term_run.delete();
    is_dig = (b >= ircansi_pkg::CH_0) && (b <= ircansi_pkg::CH_9);
    if (pmode == ircansi_pkg::MODE_AFTER_CC) begin
      if (is_dig) begin
        pmode = ircansi_pkg::MODE_DIGITS;
        ndig  = 2'd1;
        cnum  = 7'(b - ircansi_pkg::CH_0);
        bgf   = 1'b0;
      end else begin
        emit_esc("");
        pmode = ircansi_pkg::MODE_TEXT;
        plain_byte(b);
      end
    end else if (pmode == ircansi_pkg::MODE_DIGITS) begin
      if (is_dig && ndig < 2'd2) begin
        cnum = 7'(cnum * 10 + (b - ircansi_pkg::CH_0));
        ndig = ndig + 2'd1;
      end else begin
        emit_colour();
        ndig = 2'd0;
        cnum = 7'd0;
        if (b == ircansi_pkg::CH_COMMA) begin
          bgf = 1'b1;
        end else begin
          pmode = ircansi_pkg::MODE_TEXT;
          plain_byte(b);
        end
      end
    end else begin
      pmode = ircansi_pkg::MODE_TEXT;
      plain_byte(b);
    end
    if (eom) begin
      if (pmode == ircansi_pkg::MODE_AFTER_CC) emit_esc("");
      if (b != ircansi_pkg::CH_LF) emit(ircansi_pkg::CH_LF);
      clear_parse();
    end
  endfunction

  function automatic dir_row_t row(input logic [7:0] b, input logic eom,
                                   input bit typed = 1'b0, input string want = "");
    dir_row_t r;
    r.data  = b;
    r.eom   = eom;
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  function automatic void push_digit();
    msg_text.push_back(8'(ircansi_pkg::CH_0 + $urandom_range(0, 9)));
  endfunction

  function automatic void add_token();
    case ($urandom_range(0, 9))
      0, 1, 2: repeat ($urandom_range(1, 4)) msg_text.push_back(8'($urandom_range(32, 126)));
      3, 4: begin
        msg_text.push_back(ircansi_pkg::CH_CTRL_C);
        repeat ($urandom_range(0, 3)) push_digit();
        if ($urandom_range(0, 1) == 1) begin
          msg_text.push_back(ircansi_pkg::CH_COMMA);
          repeat ($urandom_range(0, 3)) push_digit();
        end
      end
      5: begin
        case ($urandom_range(0, 3))
          0: msg_text.push_back(ircansi_pkg::CH_CTRL_B);
          1: msg_text.push_back(ircansi_pkg::CH_CTRL_US);
          2: msg_text.push_back(ircansi_pkg::CH_CTRL_V);
          default: msg_text.push_back(ircansi_pkg::CH_CTRL_O);
        endcase
      end
      6: begin
        case ($urandom_range(0, 4))
          0: msg_text.push_back(ircansi_pkg::CH_TAB);
          1: msg_text.push_back(ircansi_pkg::CH_LF);
          2: msg_text.push_back(ircansi_pkg::CH_BS);
          3: msg_text.push_back(ircansi_pkg::CH_BEL);
          default: msg_text.push_back(CH_NUL);
        endcase
      end
      7: msg_text.push_back(8'($urandom_range(0, 255)));
      8: begin
        if ($urandom_range(0, 2) == 0) msg_text.push_back(ircansi_pkg::CH_COMMA);
        else push_digit();
      end
      default: begin
        msg_text.push_back(ircansi_pkg::CH_CTRL_C);
        case ($urandom_range(0, 2))
          0: msg_text.push_back(ircansi_pkg::CH_CTRL_C);
          1: msg_text.push_back(ircansi_pkg::CH_COMMA);
          default: msg_text.push_back(ircansi_pkg::CH_CTRL_O);
        endcase
      end
    endcase
  endfunction

  function automatic void build_message();
    msg_text.delete();
    repeat ($urandom_range(1, 8)) add_token();
    case ($urandom_range(0, 9))
      0: msg_text.push_back(ircansi_pkg::CH_LF);
      1: msg_text.push_back(ircansi_pkg::CH_CTRL_C);
      2: begin
        msg_text.push_back(ircansi_pkg::CH_CTRL_C);
        push_digit();
      end
      3: begin
        msg_text.push_back(ircansi_pkg::CH_CTRL_C);
        push_digit();
        msg_text.push_back(ircansi_pkg::CH_COMMA);
      end
      default: ;
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eom,
                           input bit typed, input string want);
    int  gap;
    logic last;
    if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
    gap = tx_calm ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      msg.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    msg.valid          <= 1'b1;
    msg.in_byte        <= b;
    msg.end_of_message <= eom;
    do @(posedge clk); while (!msg.ready);
    translate_byte(b, eom);
    if (typed) begin
      term_run.delete();
      for (int i = 0; i < want.len(); i++) term_run.push_back(want[i]);
    end
    for (int i = 0; i < term_run.size(); i++) begin
      last = (i == term_run.size() - 1);
      ansi_due.push_back('{term_run[i], last, eom && last});
    end
    items_sent++;
  endtask

  task automatic set_drop_beep(input logic v);
    msg.valid <= 1'b0;
    while (ansi_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    drop_beep = v;
  endtask

  // result side
  initial begin
    int         stall;
    ansi_byte_t exp_b;
    ansi.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
      stall = rx_calm ? 0 : $urandom_range(0, 17);
      if (stall != 0) begin
        ansi.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      ansi.ready <= 1'b1;
      do @(posedge clk); while (!ansi.valid);
      if (ansi_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected byte %h", ansi.out_byte));
      end else begin
        exp_b = ansi_due.pop_front();
        if (ansi.out_byte !== exp_b.data)
          flag_mismatch($sformatf("out_byte %h, want %h", ansi.out_byte, exp_b.data));
        if (ansi.last_of_run !== exp_b.last)
          flag_mismatch($sformatf("last_of_run %b, want %b on byte %h",
                                  ansi.last_of_run, exp_b.last, exp_b.data));
        if (ansi.message_done !== exp_b.done)
          flag_mismatch($sformatf("message_done %b, want %b on byte %h",
                                  ansi.message_done, exp_b.done, exp_b.data));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("[irc_format_to_ansi_translator] ERROR");
    $finish;
  end

  initial begin
    int guard;
    int phase_start;
    msg.valid          <= 1'b0;
    msg.in_byte        <= 8'h00;
    msg.end_of_message <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_wdata          <= 1'b0;
    drop_beep = 1'b0;
    clear_parse();

    dir_rows.push_back(row("A", 1'b0, 1'b1, "A"));
    dir_rows.push_back(row(CH_NUL, 1'b0));
    dir_rows.push_back(row(8'hFF, 1'b0, 1'b1, "\377"));
    dir_rows.push_back(row(ircansi_pkg::CH_TAB, 1'b0, 1'b1, " "));
    dir_rows.push_back(row(ircansi_pkg::CH_BS, 1'b0, 1'b1, ""));
    dir_rows.push_back(row(ircansi_pkg::CH_BEL, 1'b0, 1'b1, "\007"));
    dir_rows.push_back(row(ircansi_pkg::CH_LF, 1'b0, 1'b1, "\015\n"));
    dir_rows.push_back(row(ircansi_pkg::CH_CTRL_B, 1'b0, 1'b1, "\033[1m"));
    dir_rows.push_back(row(ircansi_pkg::CH_CTRL_B, 1'b0, 1'b1, "\033[22m"));
    dir_rows.push_back(row(ircansi_pkg::CH_CTRL_US, 1'b0, 1'b1, "\033[4m"));
    dir_rows.push_back(row(ircansi_pkg::CH_CTRL_V, 1'b0, 1'b1, "\033[7m"));
    dir_rows.push_back(row(ircansi_pkg::CH_CTRL_O, 1'b0, 1'b1, "\033[m"));
    // two digits, then a third digit that ends the code as text
    dir_rows.push_back(row(ircansi_pkg::CH_CTRL_C, 1'b0, 1'b1, ""));
    dir_rows.push_back(row(ircansi_pkg::CH_1, 1'b0, 1'b1, ""));
    dir_rows.push_back(row("5", 1'b0, 1'b1, ""));
    dir_rows.push_back(row(ircansi_pkg::CH_7, 1'b0));
    // foreground, comma, bright background, message end on a toggle
    dir_rows.push_back(row(ircansi_pkg::CH_CTRL_C, 1'b0));
    dir_rows.push_back(row(ircansi_pkg::CH_4, 1'b0));
    dir_rows.push_back(row(ircansi_pkg::CH_COMMA, 1'b0));
    dir_rows.push_back(row(ircansi_pkg::CH_1, 1'b0));
    dir_rows.push_back(row(ircansi_pkg::CH_1, 1'b0));
    dir_rows.push_back(row(ircansi_pkg::CH_CTRL_US, 1'b1));
    // bare ctrl-c ahead of a control byte and at message end
    dir_rows.push_back(row(ircansi_pkg::CH_CTRL_C, 1'b0));
    dir_rows.push_back(row(ircansi_pkg::CH_CTRL_V, 1'b1));
    dir_rows.push_back(row(ircansi_pkg::CH_CTRL_C, 1'b1, 1'b1, "\033[m\n"));
    dir_rows.push_back(row(ircansi_pkg::CH_LF, 1'b1, 1'b1, "\015\n"));

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_drop_beep(1'b0);

    foreach (dir_rows[i]) send_byte(dir_rows[i].data, dir_rows[i].eom,
                                    dir_rows[i].typed, dir_rows[i].want);

    for (int p = 0; p < 4; p++) begin
      set_drop_beep((p % 2) == 0);
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        build_message();
        for (int i = 0; i < msg_text.size(); i++)
          send_byte(msg_text[i], i == msg_text.size() - 1, 1'b0, "");
      end
    end
    msg.valid <= 1'b0;

    guard = 0;
    while (ansi_due.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);
    if (ansi_due.size() != 0)
      flag_mismatch($sformatf("%0d bytes never arrived", ansi_due.size()));
    if (mismatch_count == 0) begin
      $display("[irc_format_to_ansi_translator] OK");
    end else begin
      $display("[irc_format_to_ansi_translator] ERROR");
    end
    $finish;
  end

endmodule
